// File: rtl/core/dcpb_pkg.sv
`default_nettype none

package dcpb_pkg;

    localparam logic [1:0] MODE_RGB  = 2'd0;
    localparam logic [1:0] MODE_GREY = 2'd1;

    localparam logic [23:0] MASK_RGB  = 24'hFF_FFFF;
    localparam logic [23:0] MASK_GREY = 24'hFF_0000;

    localparam int unsigned APB_ADDR_W = 3;
    localparam logic REG_SEL_COLOR_MODE = 1'b0;

    typedef struct packed {
        logic       start_of_image;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } in_beat_t;

    typedef struct packed {
        logic       is_new;
        logic [7:0] entry_index;
        logic [8:0] entry_count;
        logic       dropped_full;
        logic       status;
    } out_beat_t;

endpackage

`default_nettype wire

// File: rtl/core/distinct_color_palette_builder.sv
`default_nettype none

// Builds a palette of the distinct colors in a pixel stream, in order of first appearance,
// and returns one result beat per pixel with its new flag, entry index and entry count. The
// pixel is compared with the stored entries one per cycle through the single read port of
// the palette memory, so the time from one accept to the next grows with the index of the
// matching entry, or with the number of entries held for a new color, while an unsupported
// color mode skips the scan; the worst case is a new color that is dropped because the
// palette is full. A finished result waits in the output register while the next pixel is
// accepted, and a pixel whose result is done stays in the done state as long as the
// previous result is still waiting there.
module distinct_color_palette_builder #(
    parameter int unsigned PALETTE_DEPTH = 256
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,

    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire dcpb_pkg::in_beat_t                  s_data,

    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output dcpb_pkg::out_beat_t                      m_data,

    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [dcpb_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [31:0]                         pwdata,
    output logic [31:0]                              prdata,
    output logic                                     pready
);

    localparam int unsigned IDX_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(PALETTE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(PALETTE_DEPTH);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [23:0]          palette_mem [PALETTE_DEPTH];
    logic [23:0]          rd_data_reg;
    logic [IDX_W-1:0]     rd_addr;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;

    logic [1:0]           state_reg, state_next;
    logic [1:0]           color_mode_reg, color_mode_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     scan_idx_reg, scan_idx_next;
    logic                 cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]     cmp_idx_reg, cmp_idx_next;
    logic [23:0]          key_reg, key_next;
    logic                 grey_reg, grey_next;
    dcpb_pkg::out_beat_t  res_reg, res_next;
    logic                 m_valid_reg, m_valid_next;
    dcpb_pkg::out_beat_t  m_data_reg, m_data_next;

    logic                 s_fire;
    logic                 cfg_write;
    logic [CNT_W-1:0]     count_base;
    logic [23:0]          cmp_mask;
    logic                 match;
    logic                 issue;
    logic                 scan_done;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[dcpb_pkg::APB_ADDR_W-1] == dcpb_pkg::REG_SEL_COLOR_MODE);
    assign prdata    = (paddr[dcpb_pkg::APB_ADDR_W-1] == dcpb_pkg::REG_SEL_COLOR_MODE)
                       ? {30'd0, color_mode_reg} : 32'd0;

    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign count_base = s_data.start_of_image ? '0 : count_reg;
    assign cmp_mask   = grey_reg ? dcpb_pkg::MASK_GREY : dcpb_pkg::MASK_RGB;
    assign match      = cmp_valid_reg && ((rd_data_reg & cmp_mask) == key_reg);
    assign issue      = (state_reg == ST_SCAN) && (scan_idx_reg < count_reg);
    assign scan_done  = !cmp_valid_reg && (scan_idx_reg == count_reg);
    assign rd_addr    = scan_idx_reg[IDX_W-1:0];
    assign mem_waddr  = count_reg[IDX_W-1:0];

    always_comb begin
        state_next      = state_reg;
        color_mode_next = cfg_write ? pwdata[1:0] : color_mode_reg;
        count_next      = count_reg;
        scan_idx_next   = scan_idx_reg;
        cmp_valid_next  = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        key_next        = key_reg;
        grey_next       = grey_reg;
        res_next        = res_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        mem_we          = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    count_next    = count_base;
                    scan_idx_next = '0;
                    if (color_mode_reg == dcpb_pkg::MODE_RGB) begin
                        key_next   = {s_data.red, s_data.green, s_data.blue};
                        grey_next  = 1'b0;
                        state_next = ST_SCAN;
                    end else if (color_mode_reg == dcpb_pkg::MODE_GREY) begin
                        key_next   = {s_data.red, 16'd0};
                        grey_next  = 1'b1;
                        state_next = ST_SCAN;
                    end else begin
                        res_next.is_new       = 1'b0;
                        res_next.entry_index  = 8'd0;
                        res_next.entry_count  = 9'(count_base);
                        res_next.dropped_full = 1'b0;
                        res_next.status       = 1'b1;
                        state_next            = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                if (issue) begin
                    scan_idx_next  = scan_idx_reg + 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = scan_idx_reg[IDX_W-1:0];
                end
                res_next.status = 1'b0;
                if (match) begin
                    res_next.is_new       = 1'b0;
                    res_next.entry_index  = 8'(cmp_idx_reg);
                    res_next.entry_count  = 9'(count_reg);
                    res_next.dropped_full = 1'b0;
                    state_next            = ST_DONE;
                end else if (scan_done) begin
                    if (count_reg < DEPTH_CNT) begin
                        mem_we                = 1'b1;
                        count_next            = count_reg + 1'b1;
                        res_next.is_new       = 1'b1;
                        res_next.entry_index  = 8'(count_reg);
                        res_next.entry_count  = 9'(count_reg + 1'b1);
                        res_next.dropped_full = 1'b0;
                    end else begin
                        res_next.is_new       = 1'b0;
                        res_next.entry_index  = 8'd0;
                        res_next.entry_count  = 9'(count_reg);
                        res_next.dropped_full = 1'b1;
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= palette_mem[rd_addr];
        if (mem_we) begin
            palette_mem[mem_waddr] <= key_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            color_mode_reg <= dcpb_pkg::MODE_RGB;
            count_reg      <= '0;
            cmp_valid_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            color_mode_reg <= color_mode_next;
            count_reg      <= count_next;
            cmp_valid_reg  <= cmp_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_idx_reg <= scan_idx_next;
        cmp_idx_reg  <= cmp_idx_next;
        key_reg      <= key_next;
        grey_reg     <= grey_next;
        res_reg      <= res_next;
        m_data_reg   <= m_data_next;
    end

    // The palette never holds more entries than it has room for.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_CNT)
        else $error("palette count exceeds depth");

    a_write_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (count_reg < DEPTH_CNT) && (state_reg == ST_SCAN))
        else $error("palette written while full or outside a scan");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> !s_ready)
        else $error("new beat taken while a pixel is still in work");

    a_new_is_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.is_new) |-> (!m_data_reg.dropped_full && !m_data_reg.status))
        else $error("new entry reported together with drop or error");

endmodule

`default_nettype wire
